// ----- sv/amsf_pkg.sv -----
package amsf_pkg;

   localparam int WINDOW     = 8;
   localparam int IDX_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W      = $clog2(WINDOW + 1);
   localparam int DATA_W     = 32;
   localparam int THR_W      = 31;
   localparam int GAIN_W     = 17;
   localparam int PROD_W     = GAIN_W + 1 + DATA_W + 1;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [GAIN_W-1:0]    GAIN_ONE           = GAIN_W'(65536);
   localparam logic [THR_W-1:0]     THRESHOLD_RESET    = THR_W'(65536);
   localparam logic [CSR_IDX_W-1:0] REG_STEP_THRESHOLD = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_SMOOTHING_GAIN = CSR_IDX_W'(1);

   typedef struct packed {
      logic capture;
      logic check;
      logic scan;
      logic median;
      logic mult;
      logic update;
      logic out_load;
   } amsf_cmd_type;

   typedef struct packed {
      logic step;
      logic scan_last;
   } amsf_status_type;

endpackage

// ----- sv/adaptive_median_step_filter_unit.sv -----
// Adaptive median step filter.
// req_* carries one signed Q16.16 sample per transaction, rsp_* returns one
// filtered level per sample, in order. csr_* writes the step threshold
// (index 0) and the smoothing gain (index 1); csr_ready is always high and
// writes belong to idle periods only.
// A sample that starts a new run (first after reset, or a jump at or above
// the threshold) comes back unchanged through the CHECK and PUSH states.
// Any other sample goes through a median search over the n valid window
// entries (2 to 8), which steps through one candidate entry a cycle, then
// the MEDIAN, MULT, UPDATE and PUSH states: the median, the gain multiply,
// the level update and the output load. The block takes the next sample
// only once its result is loaded into the output register.
// Reset clears the level, the window fill and the run flag and restores
// threshold 1.0 and gain 1.0; the output register is then empty.
// A stalled receiver holds rsp_tvalid and rsp_tdata; the block still
// accepts and works on the next sample and waits to load its result until
// the output register is free.
module adaptive_median_step_filter_unit
   import amsf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [DATA_W-1:0]     req_tdata,   // [31:0] sample
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [DATA_W-1:0]     rsp_tdata,   // [31:0] level
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   amsf_cmd_type    cmd;
   amsf_status_type status;

   assign csr_ready = 1'b1;

   amsf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   amsf_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .sample    (req_tdata),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .level     (rsp_tdata)
   );

endmodule

// ----- sv/amsf_ctrl.sv -----
module amsf_ctrl
   import amsf_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   input  amsf_status_type status,
   output amsf_cmd_type    cmd
);

   typedef enum logic [2:0] {
      IDLE,
      CHECK,
      SCAN,
      MEDIAN,
      MULT,
      UPDATE,
      PUSH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      load;

   assign req_tready = (state_ff == IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign load       = (state_ff == PUSH) && (!rsp_valid_ff || rsp_tready);

   assign cmd.capture  = req_tvalid && req_tready;
   assign cmd.check    = (state_ff == CHECK);
   assign cmd.scan     = (state_ff == SCAN);
   assign cmd.median   = (state_ff == MEDIAN);
   assign cmd.mult     = (state_ff == MULT);
   assign cmd.update   = (state_ff == UPDATE);
   assign cmd.out_load = load;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         IDLE: begin
            if (req_tvalid) begin
               state_in = CHECK;
            end
         end
         CHECK: begin
            state_in = status.step ? PUSH : SCAN;
         end
         SCAN: begin
            if (status.scan_last) begin
               state_in = MEDIAN;
            end
         end
         MEDIAN: state_in = MULT;
         MULT:   state_in = UPDATE;
         UPDATE: state_in = PUSH;
         PUSH: begin
            if (load) begin
               state_in     = IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- sv/amsf_datapath.sv -----
module amsf_datapath
   import amsf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [DATA_W-1:0]     sample,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  amsf_cmd_type          cmd,
   output amsf_status_type       status,
   output logic [DATA_W-1:0]     level
);

   logic signed [DATA_W-1:0] sample_ff;
   logic signed [DATA_W-1:0] level_ff, level_in;
   logic signed [DATA_W-1:0] window_ff [WINDOW];
   logic [CNT_W-1:0]         count_ff;
   logic [IDX_W-1:0]         pos_ff;
   logic                     primed_ff;
   logic [IDX_W-1:0]         scan_ff;
   logic signed [DATA_W-1:0] lo_ff, hi_ff;
   logic signed [DATA_W:0]   diff_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic [DATA_W-1:0]        out_ff;
   logic [THR_W-1:0]         thr_ff;
   logic [GAIN_W-1:0]        gain_ff;

   logic signed [DATA_W:0]   dev_diff;
   logic [DATA_W:0]          dev_abs;
   logic signed [DATA_W-1:0] cand;
   logic [CNT_W-1:0]         less_cnt, eq_cnt;
   logic [CNT_W:0]           upper;
   logic [CNT_W-1:0]         rank_lo, rank_hi;
   logic                     hit_lo, hit_hi;
   logic signed [DATA_W:0]   pair_sum;
   logic signed [DATA_W-1:0] med;
   logic [GAIN_W-1:0]        gain_eff;

   assign dev_diff = {sample_ff[DATA_W-1], sample_ff} - {level_ff[DATA_W-1], level_ff};
   assign dev_abs  = dev_diff[DATA_W] ? (DATA_W+1)'(0) - dev_diff : dev_diff;
   assign status.step = !primed_ff || (dev_abs >= {2'b00, thr_ff});

   assign cand = window_ff[scan_ff];

   always_comb begin
      less_cnt = '0;
      eq_cnt   = '0;
      for (int j = 0; j < WINDOW; j++) begin
         if (CNT_W'(j) < count_ff) begin
            if (window_ff[j] < cand) begin
               less_cnt = less_cnt + CNT_W'(1);
            end
            if (window_ff[j] == cand) begin
               eq_cnt = eq_cnt + CNT_W'(1);
            end
         end
      end
   end

   assign upper   = {1'b0, less_cnt} + {1'b0, eq_cnt};
   assign rank_lo = (count_ff - CNT_W'(1)) >> 1;
   assign rank_hi = count_ff >> 1;
   assign hit_lo  = (less_cnt <= rank_lo) && ({1'b0, rank_lo} < upper);
   assign hit_hi  = (less_cnt <= rank_hi) && ({1'b0, rank_hi} < upper);
   assign status.scan_last = (CNT_W'(scan_ff) == count_ff - CNT_W'(1));

   assign pair_sum = {lo_ff[DATA_W-1], lo_ff} + {hi_ff[DATA_W-1], hi_ff};
   assign med      = pair_sum[DATA_W:1];
   assign gain_eff = (gain_ff > GAIN_ONE) ? GAIN_ONE : gain_ff;
   assign level_in = level_ff + prod_ff[DATA_W+15:16];
   assign level    = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff    <= THRESHOLD_RESET;
         gain_ff   <= GAIN_ONE;
         level_ff  <= '0;
         count_ff  <= '0;
         pos_ff    <= '0;
         primed_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            if (csr_index == REG_STEP_THRESHOLD) begin
               thr_ff <= csr_wdata[THR_W-1:0];
            end
            if (csr_index == REG_SMOOTHING_GAIN) begin
               gain_ff <= csr_wdata[GAIN_W-1:0];
            end
         end
         if (cmd.check) begin
            if (status.step) begin
               level_ff  <= sample_ff;
               count_ff  <= CNT_W'(1);
               pos_ff    <= IDX_W'(1 % WINDOW);
               primed_ff <= 1'b1;
            end else begin
               pos_ff <= (pos_ff == IDX_W'(WINDOW - 1)) ? '0 : pos_ff + IDX_W'(1);
               if (count_ff < CNT_W'(WINDOW)) begin
                  count_ff <= count_ff + CNT_W'(1);
               end
            end
         end
         if (cmd.update) begin
            level_ff <= level_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sample_ff <= sample;
      end
      if (cmd.check) begin
         scan_ff <= '0;
         if (status.step) begin
            window_ff[0] <= sample_ff;
         end else begin
            window_ff[pos_ff] <= sample_ff;
         end
      end
      if (cmd.scan) begin
         scan_ff <= scan_ff + IDX_W'(1);
         if (hit_lo) begin
            lo_ff <= cand;
         end
         if (hit_hi) begin
            hi_ff <= cand;
         end
      end
      if (cmd.median) begin
         diff_ff <= {med[DATA_W-1], med} - {level_ff[DATA_W-1], level_ff};
      end
      if (cmd.mult) begin
         prod_ff <= PROD_W'($signed({1'b0, gain_eff}) * diff_ff);
      end
      if (cmd.out_load) begin
         out_ff <= level_ff;
      end
   end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench
   import amsf_pkg::*;
();

   localparam int QUIET_LIMIT = 4000;
   localparam int DRAIN_PAUSE = 24;
   localparam int LONG_HOLD   = 400;
   localparam int SEGMENTS    = 6;
   localparam int SEG_ITEMS   = 280;
   localparam int PLAN_LEN    = 28;

   localparam logic [CSR_IDX_W-1:0] REG_UNUSED_LO = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED_HI = CSR_IDX_W'(15);

   typedef enum logic {ROW_SAMPLE, ROW_CONFIG} row_kind_type;

   typedef struct {
      row_kind_type         kind;
      logic [CSR_IDX_W-1:0] index;
      logic [31:0]          value;
      logic                 pinned;
      logic [31:0]          level;
   } stim_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [DATA_W-1:0]     req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [DATA_W-1:0]     rsp_tdata;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   adaptive_median_step_filter_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // filter state mirror
   logic signed [31:0] hist [WINDOW];
   logic signed [31:0] level_q;
   int                 fill_q;
   int                 pos_q;
   logic               primed_q;
   logic [THR_W-1:0]   thr_q;
   logic [GAIN_W-1:0]  gain_q;

   logic [31:0] pending_levels [$];
   int          fault_count;
   int          quiet_cycles;
   int          send_idle_pct;
   int          recv_idle_pct;
   logic        hold_arm;
   logic        pin_active;
   logic [31:0] pin_level;

   stim_row_type plan [PLAN_LEN] = '{
      '{ROW_SAMPLE, REG_STEP_THRESHOLD, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF},
      '{ROW_SAMPLE, REG_STEP_THRESHOLD, 32'h8000_0000, 1'b1, 32'h8000_0000},
      '{ROW_SAMPLE, REG_STEP_THRESHOLD, 32'h8000_0064, 1'b0, 32'h0},
      '{ROW_SAMPLE, REG_STEP_THRESHOLD, 32'h8000_0000, 1'b0, 32'h0},
      '{ROW_SAMPLE, REG_STEP_THRESHOLD, 32'h8000_FFFF, 1'b0, 32'h0},
      '{ROW_SAMPLE, REG_STEP_THRESHOLD, 32'h0000_0000, 1'b1, 32'h0000_0000},
      '{ROW_SAMPLE, REG_STEP_THRESHOLD, 32'h0000_0100, 1'b0, 32'h0},
      '{ROW_SAMPLE, REG_STEP_THRESHOLD, 32'hFFFF_FF00, 1'b0, 32'h0},
      '{ROW_SAMPLE, REG_STEP_THRESHOLD, 32'h0000_7FFF, 1'b0, 32'h0},
      '{ROW_SAMPLE, REG_STEP_THRESHOLD, 32'h0000_0010, 1'b0, 32'h0},
      '{ROW_SAMPLE, REG_STEP_THRESHOLD, 32'hFFFF_FFFF, 1'b0, 32'h0},
      '{ROW_SAMPLE, REG_STEP_THRESHOLD, 32'h0000_2000, 1'b0, 32'h0},
      '{ROW_SAMPLE, REG_STEP_THRESHOLD, 32'h0000_3000, 1'b0, 32'h0},
      '{ROW_SAMPLE, REG_STEP_THRESHOLD, 32'h0000_4000, 1'b0, 32'h0},
      '{ROW_SAMPLE, REG_STEP_THRESHOLD, 32'h0000_0500, 1'b0, 32'h0},
      '{ROW_CONFIG, REG_STEP_THRESHOLD, 32'h0000_0000, 1'b0, 32'h0},
      '{ROW_SAMPLE, REG_STEP_THRESHOLD, 32'h0001_2345, 1'b1, 32'h0001_2345},
      '{ROW_SAMPLE, REG_STEP_THRESHOLD, 32'h0001_2345, 1'b1, 32'h0001_2345},
      '{ROW_CONFIG, REG_STEP_THRESHOLD, 32'hFFFF_FFFF, 1'b0, 32'h0},
      '{ROW_CONFIG, REG_SMOOTHING_GAIN, 32'h0000_0000, 1'b0, 32'h0},
      '{ROW_SAMPLE, REG_STEP_THRESHOLD, 32'h7FFF_FFFF, 1'b1, 32'h0001_2345},
      '{ROW_CONFIG, REG_SMOOTHING_GAIN, 32'h0001_FFFF, 1'b0, 32'h0},
      '{ROW_SAMPLE, REG_STEP_THRESHOLD, 32'h0002_2345, 1'b0, 32'h0},
      '{ROW_CONFIG, REG_UNUSED_LO,      32'hFFFF_FFFF, 1'b0, 32'h0},
      '{ROW_CONFIG, REG_UNUSED_HI,      32'h0000_0000, 1'b0, 32'h0},
      '{ROW_SAMPLE, REG_STEP_THRESHOLD, 32'hFFFF_0000, 1'b0, 32'h0},
      '{ROW_CONFIG, REG_STEP_THRESHOLD, 32'h0001_0000, 1'b0, 32'h0},
      '{ROW_SAMPLE, REG_STEP_THRESHOLD, 32'h0001_0000, 1'b0, 32'h0}
   };

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   function automatic logic [31:0] track_level(input logic signed [31:0] smp);
      longint             diff;
      longint             dev;
      longint             med;
      longint             sum;
      longint             g;
      longint             prod;
      logic signed [31:0] sorted [WINDOW];
      logic signed [31:0] key;
      int                 n;
      int                 j;
      diff = longint'(smp) - longint'(level_q);
      dev  = (diff < 0) ? -diff : diff;
      if (!primed_q || dev >= longint'(thr_q)) begin
         for (int i = 0; i < WINDOW; i++) hist[i] = smp;
         level_q  = smp;
         fill_q   = 1;
         pos_q    = 1 % WINDOW;
         primed_q = 1'b1;
         return smp;
      end
      hist[pos_q] = smp;
      pos_q = (pos_q + 1) % WINDOW;
      if (fill_q < WINDOW) fill_q++;
      n = fill_q;
      for (int i = 0; i < n; i++) sorted[i] = hist[i];
      for (int i = 1; i < n; i++) begin
         key = sorted[i];
         j = i;
         while (j > 0 && sorted[j-1] > key) begin
            sorted[j] = sorted[j-1];
            j--;
         end
         sorted[j] = key;
      end
      if (n % 2 == 1) begin
         med = longint'(sorted[n/2]);
      end else begin
         sum = longint'(sorted[n/2-1]) + longint'(sorted[n/2]);
         med = sum >>> 1;
      end
      g = (gain_q > GAIN_ONE) ? longint'(GAIN_ONE) : longint'(gain_q);
      prod = g * (med - longint'(level_q));
      level_q = 32'(longint'(level_q) + (prod >>> 16));
      return level_q;
   endfunction

   // mostly samples within reach of the level, some noise and extremes
   function automatic logic [31:0] shape_sample();
      int unsigned pick;
      int unsigned k;
      longint      span;
      longint      off;
      longint      v;
      pick = $urandom_range(0, 99);
      if (pick < 8) return $urandom();
      if (pick < 12) begin
         case ($urandom_range(0, 3))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
         endcase
      end
      k = $urandom_range(0, 30);
      span = longint'(1) << k;
      if (span > longint'(thr_q)) span = longint'(thr_q);
      if (span == 0) span = 1;
      off = longint'($urandom_range(0, 32'(2 * span))) - span;
      v = longint'(level_q) + off;
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[31:0];
   endfunction

   always @(posedge clock) begin : monitor
      logic        busy;
      logic [31:0] lvl;
      logic [31:0] want;
      busy = 1'b0;
      if (!reset && req_tvalid && req_tready) begin
         lvl = track_level(req_tdata);
         if (pin_active) lvl = pin_level;
         pending_levels.push_back(lvl);
         busy = 1'b1;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_levels.size() == 0) begin
            if (fault_count < 10) $display("unexpected level transaction: %h", rsp_tdata);
            fault_count++;
         end else begin
            want = pending_levels.pop_front();
            if (rsp_tdata !== want) begin
               if (fault_count < 10)
                  $display("level mismatch: expected %h, got %h", want, rsp_tdata);
               fault_count++;
            end
         end
         busy = 1'b1;
      end
      if (!reset && csr_valid && csr_ready) begin
         case (csr_index)
            REG_STEP_THRESHOLD: thr_q = csr_wdata[THR_W-1:0];
            REG_SMOOTHING_GAIN: gain_q = csr_wdata[GAIN_W-1:0];
            default: ;
         endcase
         busy = 1'b1;
      end
      quiet_cycles = busy ? 0 : quiet_cycles + 1;
   end

   initial rsp_tready = 1'b0;

   always @(negedge clock) begin : receiver
      int   hold_left;
      logic hold_used;
      if (hold_used !== 1'b1 && hold_used !== 1'b0) begin
         hold_used = 1'b0;
         hold_left = 0;
      end
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else begin
         if (hold_arm && !hold_used) begin
            hold_left = LONG_HOLD;
            hold_used = 1'b1;
         end
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("Verification failed");
      $finish;
   end

   task automatic send_sample(input logic [31:0] v, input logic pinned, input logic [31:0] lvl);
      @(negedge clock);
      pin_active = pinned;
      pin_level  = lvl;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= v;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] data);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_levels.size() != 0) @(negedge clock);
      repeat (DRAIN_PAUSE) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [31:0] thr_val;
      logic [31:0] gain_val;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      csr_valid    = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      hold_arm     = 1'b0;
      pin_active   = 1'b0;
      pin_level    = '0;
      fault_count  = 0;
      quiet_cycles = 0;
      for (int i = 0; i < WINDOW; i++) hist[i] = '0;
      level_q  = '0;
      fill_q   = 0;
      pos_q    = 0;
      primed_q = 1'b0;
      thr_q    = THRESHOLD_RESET;
      gain_q   = GAIN_ONE;
      send_idle_pct = 11;
      recv_idle_pct = 57;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[r]) begin
         if (plan[r].kind == ROW_CONFIG) write_csr(plan[r].index, plan[r].value);
         else send_sample(plan[r].value, plan[r].pinned, plan[r].level);
      end

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         case (seg)
            0: begin thr_val = 32'h0010_0000;                gain_val = 32'h0000_8000; end
            1: begin thr_val = 32'h7FFF_FFFF;                gain_val = 32'h0001_FFFF; end
            2: begin thr_val = $urandom();                   gain_val = $urandom(); end
            3: begin thr_val = 32'h0000_0001;                gain_val = 32'h0000_0001; end
            4: begin thr_val = $urandom_range(1024, 1 << 24); gain_val = 32'(GAIN_ONE); end
            default: begin thr_val = $urandom_range(1 << 12, 1 << 20); gain_val = 32'h0; end
         endcase
         if (seg == 2) begin
            send_idle_pct = 57;
            recv_idle_pct = 11;
         end else if (seg == 4) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_csr(REG_STEP_THRESHOLD, {1'($urandom()), thr_val[THR_W-1:0]});
         write_csr(REG_SMOOTHING_GAIN, {15'($urandom()), gain_val[GAIN_W-1:0]});
         write_csr(CSR_IDX_W'($urandom_range(2, 15)), $urandom());
         for (int n = 0; n < SEG_ITEMS; n++) begin
            if (seg == 4 && n == 50) hold_arm = 1'b1;
            send_sample(shape_sample(), 1'b0, 32'h0);
         end
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_levels.size() != 0) @(negedge clock);
      repeat (DRAIN_PAUSE) @(negedge clock);
      fault_count += pending_levels.size();
      if (fault_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
